### rtl/core/cft_pkg.sv
// cft_pkg: types, token codes and byte constants shared by the csv field tokenizer
// depends on nothing
`timescale 1ns / 1ps

package cft_pkg;

   localparam logic [7:0] QUOTE_BYTE = 8'h22;
   localparam logic [7:0] COMMA_BYTE = 8'h2C;

   // token kinds on the result channel
   localparam logic [1:0] TOK_VALUE      = 2'd0;
   localparam logic [1:0] TOK_FIELD_END  = 2'd1;
   localparam logic [1:0] TOK_RECORD_END = 2'd2;

   // input kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] token_kind;
      logic [7:0] value_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] token_kind;
      logic [7:0] value_byte;
   } token_type;

   // one input item's worth of tokens, from one to four
   typedef struct packed {
      logic [1:0]      last_idx;
      token_type [3:0] tok;
   } entry_type;

   // utf-8 byte-order mark, byte k of three
   function automatic logic [7:0] bom_byte(input logic [1:0] k);
      case (k)
         2'd0:    bom_byte = 8'hEF;
         2'd1:    bom_byte = 8'hBB;
         2'd2:    bom_byte = 8'hBF;
         default: bom_byte = 8'h00;
      endcase
   endfunction

endpackage

### rtl/core/csv_field_tokenizer.sv
// csv_field_tokenizer: top level, front classifier, token queue and result back end
// depends on cft_pkg, cft_front, cft_queue, cft_back
`timescale 1ns / 1ps

// The tokenizer takes one line byte or end-of-line item per cycle while
// req_ready is high and returns value bytes, field ends and record ends, one
// result per cycle while rsp_ready is high, with last set on the final result
// of each input item. The front classifies an item in the cycle it is
// accepted and pushes its one to four tokens as one entry into a four-entry
// queue; items that give no result (held byte-order-mark bytes, opening and
// closing quotes) push nothing. req_ready is high whenever the queue has room,
// so input runs at one item per cycle as long as the results drain. The back
// end sends one token per cycle from a registered output while rsp_ready is
// high, so the sustained input rate is set by the one result per cycle at
// the output. rsp_valid rises only once the item's entry is in the queue and
// its first token has been loaded into the result register.

module csv_field_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cft_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cft_pkg::rsp_type rsp_payload
);
   import cft_pkg::*;

   // front to queue
   logic      q_push;
   entry_type q_data;
   logic      q_full;

   // queue to back
   entry_type q_head;
   logic      q_empty;
   logic      q_pop;

   // classification and parse state, one item per cycle while the queue has room
   cft_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   // decoupling queue, lets input and result side stall independently
   cft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // token serialiser and result register
   cft_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/core/cft_front.sv
// cft_front: parse state and classification of one input item into its tokens
// depends on cft_pkg
`timescale 1ns / 1ps

module cft_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cft_pkg::req_type   req_payload,
   input  logic               q_full,
   output logic               q_push,
   output cft_pkg::entry_type q_data
);
   import cft_pkg::*;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_PLAIN  = 2'd1,
      PH_QUOTED = 2'd2,
      PH_QSEEN  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0] n;
      token_type  t0;
      token_type  t1;
      phase_type  ph;
   } feed_type;

   function automatic feed_type feed(input phase_type ph, input logic [7:0] b);
      feed_type f;
      f.n  = 2'd0;
      f.t0 = '{token_kind: TOK_VALUE, value_byte: b};
      f.t1 = '{token_kind: TOK_VALUE, value_byte: b};
      f.ph = ph;
      case (ph)
         PH_START: begin
            if (b == QUOTE_BYTE) begin
               f.ph = PH_QUOTED;
            end else if (b == COMMA_BYTE) begin
               f.n  = 2'd1;
               f.t0 = '{token_kind: TOK_FIELD_END, value_byte: 8'h00};
            end else begin
               f.n  = 2'd1;
               f.ph = PH_PLAIN;
            end
         end
         PH_PLAIN: begin
            f.n = 2'd1;
            if (b == COMMA_BYTE) begin
               f.t0 = '{token_kind: TOK_FIELD_END, value_byte: 8'h00};
               f.ph = PH_START;
            end
         end
         PH_QUOTED: begin
            if (b == QUOTE_BYTE) begin
               f.ph = PH_QSEEN;
            end else begin
               f.n = 2'd1;
            end
         end
         PH_QSEEN: begin
            if (b == QUOTE_BYTE) begin
               f.n  = 2'd1;
               f.ph = PH_QUOTED;
            end else if (b == COMMA_BYTE) begin
               f.n  = 2'd1;
               f.t0 = '{token_kind: TOK_FIELD_END, value_byte: 8'h00};
               f.ph = PH_START;
            end else begin
               // closing quote then other byte: end field, open an unquoted one
               f.n  = 2'd2;
               f.t0 = '{token_kind: TOK_FIELD_END, value_byte: 8'h00};
               f.ph = PH_PLAIN;
            end
         end
         default: f.n = 2'd0;
      endcase
      return f;
   endfunction

   phase_type       phase_ff, phase_in;
   logic [1:0]      bom_ff, bom_in;
   logic            start_ff, start_in;
   token_type [3:0] tok;
   logic [2:0]      cnt;
   feed_type        f;
   logic            accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      bom_in   = bom_ff;
      start_in = start_ff;
      tok      = '0;
      cnt      = 3'd0;
      f        = feed(phase_ff, req_payload.data_byte);
      if (req_payload.kind == KIND_EOL) begin
         // held mark bytes become an unquoted field
         if (start_ff && bom_ff != 2'd0) begin
            tok[0]   = '{token_kind: TOK_VALUE, value_byte: bom_byte(2'd0)};
            cnt      = 3'd1;
            phase_in = PH_PLAIN;
            if (bom_ff == 2'd2) begin
               tok[1] = '{token_kind: TOK_VALUE, value_byte: bom_byte(2'd1)};
               cnt    = 3'd2;
            end
         end
         if (phase_in != PH_START) begin
            tok[cnt[1:0]] = '{token_kind: TOK_FIELD_END, value_byte: 8'h00};
            cnt           = cnt + 3'd1;
         end
         tok[cnt[1:0]] = '{token_kind: TOK_RECORD_END, value_byte: 8'h00};
         cnt           = cnt + 3'd1;
         phase_in      = PH_START;
         bom_in        = 2'd0;
         start_in      = 1'b1;
      end else begin
         if (start_ff && bom_ff != 2'd3 &&
             req_payload.data_byte == bom_byte(bom_ff)) begin
            // mark byte held back, full mark discarded
            if (bom_ff == 2'd2) begin
               bom_in   = 2'd0;
               start_in = 1'b0;
            end else begin
               bom_in = bom_ff + 2'd1;
            end
         end else begin
            if (start_ff && bom_ff != 2'd0) begin
               tok[0]   = '{token_kind: TOK_VALUE, value_byte: bom_byte(2'd0)};
               cnt      = 3'd1;
               phase_in = PH_PLAIN;
               if (bom_ff == 2'd2) begin
                  tok[1] = '{token_kind: TOK_VALUE, value_byte: bom_byte(2'd1)};
                  cnt    = 3'd2;
               end
            end
            start_in = 1'b0;
            bom_in   = 2'd0;
            f        = feed(phase_in, req_payload.data_byte);
            if (f.n != 2'd0) begin
               tok[cnt[1:0]] = f.t0;
               cnt           = cnt + 3'd1;
            end
            if (f.n == 2'd2) begin
               tok[cnt[1:0]] = f.t1;
               cnt           = cnt + 3'd1;
            end
            phase_in = f.ph;
         end
      end
   end

   assign q_push          = accept && (cnt != 3'd0);
   assign q_data.tok      = tok;
   assign q_data.last_idx = 2'(cnt - 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         bom_ff   <= 2'd0;
         start_ff <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         bom_ff   <= bom_in;
         start_ff <= start_in;
      end
   end

endmodule

### rtl/core/cft_queue.sv
// cft_queue: short register queue of token entries between front and back
// depends on cft_pkg
`timescale 1ns / 1ps

module cft_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cft_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output cft_pkg::entry_type head,
   output logic               empty
);
   import cft_pkg::*;

   entry_type          mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/cft_back.sv
// cft_back: walks each queued entry and drives the registered result channel
// depends on cft_pkg
`timescale 1ns / 1ps

module cft_back (
   input  logic               clock,
   input  logic               reset,
   input  cft_pkg::entry_type head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cft_pkg::rsp_type   rsp_payload
);
   import cft_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       at_last;

   assign load    = !q_empty && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == head.last_idx);
   assign q_pop   = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in          = 1'b1;
         rsp_in.token_kind = head.tok[idx_ff].token_kind;
         rsp_in.value_byte = head.tok[idx_ff].value_byte;
         rsp_in.last       = at_last;
         idx_in            = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   a_idx_in_entry: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> idx_ff <= head.last_idx)
      else $error("token index beyond end of queued entry");

   a_mid_entry_held: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> !q_empty)
      else $error("partly sent entry left the queue");

   a_rest_pending: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ff.last |-> !q_empty)
      else $error("result without last but no tokens left");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !valid_ff && idx_ff == 2'd0)
      else $error("back end not idle after reset");

endmodule
